/* hdl/tls_pkg.sv */
// Shared types, codes and character helpers for the token lexer stream.
package tls_pkg;

    localparam int MAX_LEXEME_DEF = 255;
    localparam int POS_BITS_DEF   = 16;
    localparam int RQ_DEPTH       = 4;
    localparam int RQ_PTR_BITS    = $clog2(RQ_DEPTH);

    localparam logic [62:0] VAL_MAX = {63{1'b1}};

    // Token kinds.
    localparam logic [3:0] K_INT     = 4'd0;
    localparam logic [3:0] K_FLOAT   = 4'd1;
    localparam logic [3:0] K_PLUS    = 4'd2;
    localparam logic [3:0] K_MINUS   = 4'd3;
    localparam logic [3:0] K_TIMES   = 4'd4;
    localparam logic [3:0] K_DIVIDE  = 4'd5;
    localparam logic [3:0] K_PRINT   = 4'd6;
    localparam logic [3:0] K_STRING  = 4'd7;
    localparam logic [3:0] K_LPAREN  = 4'd8;
    localparam logic [3:0] K_RPAREN  = 4'd9;
    localparam logic [3:0] K_SEMI    = 4'd10;
    localparam logic [3:0] K_QUOTE   = 4'd11;
    localparam logic [3:0] K_HASH    = 4'd12;
    localparam logic [3:0] K_NEWLINE = 4'd13;
    localparam logic [3:0] K_IDENT   = 4'd15;

    // Fault codes.
    localparam logic [1:0] F_NONE    = 2'd0;
    localparam logic [1:0] F_CHAR    = 2'd1;
    localparam logic [1:0] F_LONG    = 2'd2;
    localparam logic [1:0] F_UNTERM  = 2'd3;

    // Characters of interest.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_TIMES  = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UPPA   = 8'h41;
    localparam logic [7:0] CH_UPPZ   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOWA   = 8'h61;
    localparam logic [7:0] CH_LOWZ   = 8'h7A;

    localparam logic [2:0] KW_LEN    = 3'd5;

    typedef enum logic [2:0] {
        M_IDLE,
        M_INT,
        M_FRAC,
        M_IDENT,
        M_STRING,
        M_HALTED
    } t_mode;

    typedef struct packed {
        logic [3:0]  kind;
        logic [62:0] value;
        logic [15:0] start;
        logic [7:0]  len;
        logic [1:0]  fault;
        logic        last;
    } t_tok;

    // Up to two tokens produced by one byte.
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok1;
        t_tok       tok0;
    } t_step;

    function automatic t_tok mk_tok(logic [3:0] kind, logic [62:0] value,
                                    logic [15:0] start, logic [7:0] len,
                                    logic [1:0] fault);
        t_tok t;
        t.kind  = kind;
        t.value = value;
        t.start = start;
        t.len   = len;
        t.fault = fault;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= CH_LOWA) && (c <= CH_LOWZ)) || ((c >= CH_UPPA) && (c <= CH_UPPZ));
    endfunction

    // Space, tab, newline, vertical tab, form feed and carriage return.
    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Letters of the keyword "print"; zero past its end.
    function automatic logic [7:0] kw_char(logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h70;
            3'd1:    r = 8'h72;
            3'd2:    r = 8'h69;
            3'd3:    r = 8'h6E;
            3'd4:    r = 8'h74;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Single-character tokens: {hit, kind}.
    function automatic logic [4:0] op_lookup(logic [7:0] c);
        logic [4:0] r;
        unique case (c)
            CH_PLUS:   r = {1'b1, K_PLUS};
            CH_MINUS:  r = {1'b1, K_MINUS};
            CH_TIMES:  r = {1'b1, K_TIMES};
            CH_SLASH:  r = {1'b1, K_DIVIDE};
            CH_LPAREN: r = {1'b1, K_LPAREN};
            CH_RPAREN: r = {1'b1, K_RPAREN};
            CH_SEMI:   r = {1'b1, K_SEMI};
            CH_HASH:   r = {1'b1, K_HASH};
            default:   r = {1'b0, K_INT};
        endcase
        return r;
    endfunction

    // Token for a pending number or identifier when it is closed.
    function automatic t_tok flush_tok(t_mode mode, logic [62:0] accum,
                                       logic [15:0] start, logic [7:0] len,
                                       logic [2:0] kwp, logic kwm);
        logic [3:0] k;
        unique case (mode)
            M_INT:   k = K_INT;
            M_FRAC:  k = K_FLOAT;
            default: k = (!kwm && kwp == KW_LEN) ? K_PRINT : K_IDENT;
        endcase
        return mk_tok(k, (mode == M_IDENT) ? 63'd0 : accum, start, len, F_NONE);
    endfunction

endpackage

/* hdl/tls_core.sv */
// Lexer state registers and the single-pass next-state and token logic.
module tls_core #(
    parameter int MAX_LEXEME = tls_pkg::MAX_LEXEME_DEF,
    parameter int POS_BITS   = tls_pkg::POS_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_ch,
    input  logic          i_eot,
    output tls_pkg::t_step o_step
);
    import tls_pkg::*;

    localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};
    localparam logic [7:0]          LEN_MAX = 8'(MAX_LEXEME);

    t_mode               r_mode,  n_mode;
    logic [62:0]         r_accum, n_accum;
    logic [POS_BITS-1:0] r_start, n_start;
    logic [7:0]          r_len,   n_len;
    logic [2:0]          r_kwp,   n_kwp;
    logic                r_kwm,   n_kwm;
    logic [POS_BITS-1:0] r_pos,   n_pos;

    t_tok        w_tok [2];
    logic [1:0]  w_cnt;
    logic        w_faulted;
    logic        w_go_idle;
    logic        w_active;
    logic        w_full;
    logic        w_kw_hit;
    logic [3:0]  w_dig;
    logic [66:0] w_acc_ext;
    logic [62:0] w_acc_next;
    logic [15:0] w_p16;
    logic [15:0] w_start16;
    logic [4:0]  w_op;

    assign w_dig      = 4'(i_ch - CH_ZERO);
    // accum * 10 + digit; saturates once it passes the 63-bit maximum.
    assign w_acc_ext  = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + 67'(w_dig);
    assign w_acc_next = (w_acc_ext[66:63] != 4'd0) ? VAL_MAX : w_acc_ext[62:0];
    assign w_full     = r_len >= LEN_MAX;
    assign w_kw_hit   = !r_kwm && (r_len < 8'(KW_LEN)) && (i_ch == kw_char(r_len[2:0]));
    assign w_p16      = 16'(r_pos);
    assign w_start16  = 16'(r_start);
    assign w_op       = op_lookup(i_ch);
    assign w_active   = r_mode != M_HALTED;

    always_comb begin
        n_mode    = r_mode;
        n_accum   = r_accum;
        n_start   = r_start;
        n_len     = r_len;
        n_kwp     = r_kwp;
        n_kwm     = r_kwm;
        n_pos     = r_pos + POS_ONE;
        w_tok[0]  = mk_tok(K_INT, 63'd0, 16'd0, 8'd0, F_NONE);
        w_tok[1]  = mk_tok(K_INT, 63'd0, 16'd0, 8'd0, F_NONE);
        w_cnt     = 2'd0;
        w_faulted = 1'b0;
        w_go_idle = 1'b0;

        // Continue or close the lexeme in progress.
        unique case (r_mode)
            M_INT: begin
                if (is_digit(i_ch) || i_ch == CH_DOT) begin
                    if (w_full) begin
                        w_tok[w_cnt[0]] = mk_tok(K_INT, 63'd0, w_start16, r_len, F_LONG);
                        w_cnt = w_cnt + 2'd1;
                        w_faulted = 1'b1;
                    end else begin
                        n_len = r_len + 8'd1;
                        if (is_digit(i_ch)) begin
                            n_accum = w_acc_next;
                        end else begin
                            n_mode = M_FRAC;
                        end
                    end
                end else begin
                    w_tok[w_cnt[0]] = flush_tok(r_mode, r_accum, w_start16, r_len, r_kwp, r_kwm);
                    w_cnt = w_cnt + 2'd1;
                    w_go_idle = 1'b1;
                end
            end
            M_FRAC: begin
                if (is_digit(i_ch)) begin
                    if (w_full) begin
                        w_tok[w_cnt[0]] = mk_tok(K_FLOAT, 63'd0, w_start16, r_len, F_LONG);
                        w_cnt = w_cnt + 2'd1;
                        w_faulted = 1'b1;
                    end else begin
                        n_len = r_len + 8'd1;
                    end
                end else begin
                    w_tok[w_cnt[0]] = flush_tok(r_mode, r_accum, w_start16, r_len, r_kwp, r_kwm);
                    w_cnt = w_cnt + 2'd1;
                    w_go_idle = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_alpha(i_ch) || is_digit(i_ch) || i_ch == CH_UNDER) begin
                    if (w_full) begin
                        w_tok[w_cnt[0]] = mk_tok(K_IDENT, 63'd0, w_start16, r_len, F_LONG);
                        w_cnt = w_cnt + 2'd1;
                        w_faulted = 1'b1;
                    end else begin
                        n_len = r_len + 8'd1;
                        if (w_kw_hit) begin
                            n_kwp = r_kwp + 3'd1;
                        end else begin
                            n_kwm = 1'b1;
                        end
                    end
                end else begin
                    w_tok[w_cnt[0]] = flush_tok(r_mode, r_accum, w_start16, r_len, r_kwp, r_kwm);
                    w_cnt = w_cnt + 2'd1;
                    w_go_idle = 1'b1;
                end
            end
            M_STRING: begin
                if (i_ch == CH_QUOTE) begin
                    w_tok[0] = mk_tok(K_STRING, 63'd0, w_start16, r_len, F_NONE);
                    w_tok[1] = mk_tok(K_QUOTE, 63'd0, w_p16, 8'd1, F_NONE);
                    w_cnt = 2'd2;
                    n_mode = M_IDLE;
                end else if (w_full) begin
                    w_tok[0] = mk_tok(K_STRING, 63'd0, w_start16, r_len, F_LONG);
                    w_cnt = 2'd1;
                    w_faulted = 1'b1;
                end else begin
                    n_len = r_len + 8'd1;
                end
            end
            M_IDLE: begin
                w_go_idle = 1'b1;
            end
            default: begin
            end
        endcase

        // Start a new token with this byte.
        if (w_go_idle) begin
            n_mode = M_IDLE;
            if (is_space(i_ch)) begin
                if (i_ch == CH_NL) begin
                    w_tok[w_cnt[0]] = mk_tok(K_NEWLINE, 63'd0, w_p16, 8'd1, F_NONE);
                    w_cnt = w_cnt + 2'd1;
                end
            end else if (is_digit(i_ch)) begin
                n_mode  = M_INT;
                n_start = r_pos;
                n_len   = 8'd1;
                n_accum = 63'(w_dig);
            end else if (is_alpha(i_ch)) begin
                n_mode  = M_IDENT;
                n_start = r_pos;
                n_len   = 8'd1;
                n_kwp   = (i_ch == kw_char(3'd0)) ? 3'd1 : 3'd0;
                n_kwm   = i_ch != kw_char(3'd0);
            end else if (i_ch == CH_QUOTE) begin
                w_tok[w_cnt[0]] = mk_tok(K_QUOTE, 63'd0, w_p16, 8'd1, F_NONE);
                w_cnt = w_cnt + 2'd1;
                n_mode  = M_STRING;
                n_start = r_pos + POS_ONE;
                n_len   = 8'd0;
            end else if (w_op[4]) begin
                w_tok[w_cnt[0]] = mk_tok(w_op[3:0], 63'd0, w_p16, 8'd1, F_NONE);
                w_cnt = w_cnt + 2'd1;
            end else begin
                w_tok[w_cnt[0]] = mk_tok(K_INT, 63'd0, w_p16, 8'd1, F_CHAR);
                w_cnt = w_cnt + 2'd1;
                w_faulted = 1'b1;
            end
        end

        // Final byte: flush what is pending, then return to the reset state.
        if (i_eot) begin
            if (w_active && !w_faulted) begin
                if (n_mode == M_STRING) begin
                    if (w_cnt == 2'd2) begin
                        w_tok[1].fault = F_UNTERM;
                    end else begin
                        w_tok[w_cnt[0]] = mk_tok(K_STRING, 63'd0, 16'(n_start), n_len,
                                                 F_UNTERM);
                        w_cnt = w_cnt + 2'd1;
                    end
                end else if (n_mode inside {M_INT, M_FRAC, M_IDENT}) begin
                    w_tok[w_cnt[0]] = flush_tok(n_mode, n_accum, 16'(n_start), n_len,
                                                n_kwp, n_kwm);
                    w_cnt = w_cnt + 2'd1;
                end
            end
            n_mode  = M_IDLE;
            n_accum = 63'd0;
            n_start = '0;
            n_len   = 8'd0;
            n_kwp   = 3'd0;
            n_kwm   = 1'b0;
            n_pos   = '0;
        end else if (w_faulted) begin
            n_mode = M_HALTED;
        end

        if (w_cnt != 2'd0) begin
            w_tok[w_cnt[1]].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_accum <= 63'd0;
            r_start <= '0;
            r_len   <= 8'd0;
            r_kwp   <= 3'd0;
            r_kwm   <= 1'b0;
            r_pos   <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_accum <= n_accum;
            r_start <= n_start;
            r_len   <= n_len;
            r_kwp   <= n_kwp;
            r_kwm   <= n_kwm;
            r_pos   <= n_pos;
        end
    end

    assign o_step.cnt  = i_fire ? w_cnt : 2'd0;
    assign o_step.tok0 = w_tok[0];
    assign o_step.tok1 = w_tok[1];

endmodule

/* hdl/tls_rq.sv */
// Small result queue that takes up to two tokens per cycle and hands out one.
module tls_rq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tls_pkg::t_step i_step,
    input  logic           i_pop,
    output tls_pkg::t_tok  o_tok,
    output logic           o_valid,
    output logic           o_room2
);
    import tls_pkg::*;

    t_tok                   r_mem [RQ_DEPTH];
    logic [RQ_PTR_BITS-1:0] r_wr, n_wr;
    logic [RQ_PTR_BITS-1:0] r_rd, n_rd;
    logic [RQ_PTR_BITS:0]   r_cnt, n_cnt;
    logic                   w_pop;

    assign o_valid = r_cnt != '0;
    assign o_room2 = r_cnt <= (RQ_PTR_BITS+1)'(RQ_DEPTH - 2);
    assign o_tok   = r_mem[r_rd];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr + RQ_PTR_BITS'(i_step.cnt);
        n_rd  = r_rd + RQ_PTR_BITS'(w_pop);
        n_cnt = r_cnt + (RQ_PTR_BITS+1)'(i_step.cnt) - (RQ_PTR_BITS+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.cnt != 2'd0) begin
            r_mem[r_wr] <= i_step.tok0;
        end
        if (i_step.cnt == 2'd2) begin
            r_mem[r_wr + RQ_PTR_BITS'(1)] <= i_step.tok1;
        end
    end

endmodule

/* hdl/token_lexer_stream.sv */
// Top level of the streaming lexer: input register, lexer core and result queue.
//
//  Channel  Direction  Handshake                   Beat payload
//  -------  ---------  --------------------------  ----------------------------------------
//  in       sink       i_in_valid / o_in_ready     i_ch, i_end_of_text
//  out      source     o_out_valid / i_out_ready   o_kind, o_value, o_start_res, o_length,
//                                                  o_fault, o_run_end
//
// One byte is taken per cycle while the queue has room for two tokens; only then does the
// input register move on. An accepted beat waits there, and a single combinational pass
// updates the lexer state and writes zero, one or two tokens into the four-entry result
// queue; a token shows on the out channel once it is in the queue and at its head. A stalled
// out channel stalls the in channel once the queue holds more than two tokens.
// Reset is synchronous and active low; it empties the queue and idles the lexer at zero.
module token_lexer_stream #(
    parameter int MAX_LEXEME = tls_pkg::MAX_LEXEME_DEF,
    parameter int POS_BITS   = tls_pkg::POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_kind,
    output logic [62:0] o_value,
    output logic [15:0] o_start_res,
    output logic [7:0]  o_length,
    output logic [1:0]  o_fault,
    output logic        o_run_end
);
    import tls_pkg::*;

    // Input register: one byte waiting to be lexed.
    logic       r_in_vld;
    logic [7:0] r_ch;
    logic       r_eot;

    logic  w_fire;
    logic  w_room2;
    t_step w_step;
    t_tok  w_head;

    // The held byte is lexed when the queue can take both tokens it may produce.
    assign w_fire     = r_in_vld && w_room2;
    assign o_in_ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ch  <= i_ch;
            r_eot <= i_end_of_text;
        end
    end

    tls_core #(
        .MAX_LEXEME(MAX_LEXEME),
        .POS_BITS  (POS_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_fire (w_fire),
        .i_ch   (r_ch),
        .i_eot  (r_eot),
        .o_step (w_step)
    );

    tls_rq u_rq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_step (w_step),
        .i_pop  (i_out_ready),
        .o_tok  (w_head),
        .o_valid(o_out_valid),
        .o_room2(w_room2)
    );

    // Each beat on the out channel is the token at the head of the queue.
    assign o_kind      = w_head.kind;
    assign o_value     = w_head.value;
    assign o_start_res = w_head.start;
    assign o_length    = w_head.len;
    assign o_fault     = w_head.fault;
    assign o_run_end   = w_head.last;

endmodule
